// File: rtl/top_k_candidate_list_unit_defines.svh
// assertion macros shared by the candidate list modules
`ifndef TOP_K_CANDIDATE_LIST_UNIT_DEFINES_SVH
`define TOP_K_CANDIDATE_LIST_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on every rising aclk outside reset
`define TKCL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("tkcl assertion failed");
// implication checked on every rising aclk outside reset
`define TKCL_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tkcl implication failed");
`else
`define TKCL_ASSERT(lbl, prop)
`define TKCL_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

// File: rtl/tkcl_pkg.sv
// types, widths and codes shared by the candidate list modules
package tkcl_pkg;

    localparam int LIST_DEPTH = 8;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam int ID_W       = 16;
    localparam int SCORE_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int RANK_W     = 3;
    localparam int COUNT_W    = 4;

    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_PAYLOAD_W = RANK_W + ID_W + SCORE_W + COUNT_W;
    localparam int M_TDATA_W  = 40;
    localparam int M_PAD_W    = M_TDATA_W - M_PAYLOAD_W;
    localparam int M_TUSER_W  = STATUS_W;

    // request kinds carried in s_tuser bit 0
    localparam logic ACT_CLEAR = 1'b0;
    localparam logic ACT_OFFER = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_CLEARED    = 3'd0,
        STAT_INSERTED   = 3'd1,
        STAT_NO_CHANCE  = 3'd2,
        STAT_DUPLICATE  = 3'd3,
        STAT_FULL_WORSE = 3'd4
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_LIST
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic req_load;
        logic cnt_clear;
        logic insert;
        logic out_load_status;
        logic out_load_entry;
        logic idx_clr;
        logic idx_inc;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        status_t verdict;
        logic    idx_last;
    } dp_stat_t;

endpackage

// File: rtl/top_k_candidate_list_unit.sv
// Top-k candidate list: keeps the best candidates (lowest score) in rank order.
// Requests arrive on the s_ stream: s_tuser[0] is the action (clear or offer),
// s_tuser[1] the no-chance flag, s_tdata holds cand_id and cand_score.
// Results leave on the m_ stream: m_tuser is the status code, m_tdata holds
// rank, entry_id, entry_score and entry_count, m_tlast marks the final result
// of a request.
// A clear, or an offer that is turned away, gives one result, loaded from the
// decide state once the result register is free. An accepted offer gives one
// result per held entry: the decide state inserts the candidate, then the
// listing state reads the held entries out in rank order, one entry per cycle
// while the result register is free.
// Reset empties the list and drops any result not yet taken.
// While m_tready is low the result register holds its item and the listing
// pauses; the next request can be taken as soon as the final result of the
// previous one sits in the result register.
module top_k_candidate_list_unit
    import tkcl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // cand_id, cand_score, from bit 0 up
    input  logic [S_TUSER_W-1:0] s_tuser,   // action, no_chance, from bit 0 up
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // rank, entry_id, entry_score, entry_count, pad
    output logic [M_TUSER_W-1:0] m_tuser,   // status
    output logic                 m_tlast
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencing
    tkcl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // list storage and result register
    tkcl_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// File: rtl/tkcl_datapath.sv
// candidate list storage, compare row, insertion cells and result register
`include "top_k_candidate_list_unit_defines.svh"

module tkcl_datapath
    import tkcl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic [S_TDATA_W-1:0] s_tdata,   // cand_id, cand_score, from bit 0 up
    input  logic [S_TUSER_W-1:0] s_tuser,   // action, no_chance, from bit 0 up
    output logic [M_TDATA_W-1:0] m_tdata,   // rank, entry_id, entry_score, entry_count, pad
    output logic [M_TUSER_W-1:0] m_tuser,   // status
    output logic                 m_tlast
);

    // latched request
    logic               req_action_reg;
    logic               req_no_chance_reg;
    logic [ID_W-1:0]    req_id_reg;
    logic [SCORE_W-1:0] req_score_reg;

    // held list
    logic [ID_W-1:0]    held_id_reg    [LIST_DEPTH];
    logic [SCORE_W-1:0] held_score_reg [LIST_DEPTH];
    logic [CNT_W-1:0]   held_count_reg;
    logic [CNT_W-1:0]   held_count_next;

    // listing index
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    // result register
    status_t            out_status_reg;
    logic [RANK_W-1:0]  out_rank_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [SCORE_W-1:0] out_score_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_last_reg;

    logic [LIST_DEPTH-1:0] id_match;
    logic [LIST_DEPTH-1:0] score_le;
    logic [CNT_W-1:0]      ins_pos;
    logic                  pos_full;
    status_t               verdict;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_id_reg        <= s_tdata[ID_W-1:0];
            req_score_reg     <= s_tdata[ID_W +: SCORE_W];
            req_action_reg    <= s_tuser[0];
            req_no_chance_reg <= s_tuser[1];
        end
    end

    // compare row against every held entry
    always_comb begin
        for (int k = 0; k < LIST_DEPTH; k++) begin
            id_match[k] = (CNT_W'(k) < held_count_reg) && (held_id_reg[k] == req_id_reg);
            score_le[k] = (CNT_W'(k) < held_count_reg) &&
                          (held_score_reg[k] <= req_score_reg);
        end
    end

    // insertion point follows every entry with equal or lower score
    assign ins_pos  = CNT_W'($countones(score_le));
    assign pos_full = (ins_pos == CNT_W'(LIST_DEPTH));

    // verdict, checks in priority order
    always_comb begin
        priority if (req_action_reg == ACT_CLEAR) begin
            verdict = STAT_CLEARED;
        end else if (req_no_chance_reg) begin
            verdict = STAT_NO_CHANCE;
        end else if (|id_match) begin
            verdict = STAT_DUPLICATE;
        end else if (pos_full) begin
            verdict = STAT_FULL_WORSE;
        end else begin
            verdict = STAT_INSERTED;
        end
    end

    assign stat.verdict  = verdict;
    assign stat.idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == held_count_reg);

    // insertion cells: keep, take the new candidate, or take the upper neighbour
    for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
        logic [ID_W-1:0]    cell_id;
        logic [SCORE_W-1:0] cell_score;
        if (k == 0) begin : g_head
            assign cell_id    = req_id_reg;
            assign cell_score = req_score_reg;
        end else begin : g_body
            assign cell_id    = (CNT_W'(k) > ins_pos) ? held_id_reg[k-1] : req_id_reg;
            assign cell_score = (CNT_W'(k) > ins_pos) ? held_score_reg[k-1] : req_score_reg;
        end
        always_ff @(posedge aclk) begin
            if (cmd.insert && (CNT_W'(k) >= ins_pos)) begin
                held_id_reg[k]    <= cell_id;
                held_score_reg[k] <= cell_score;
            end
        end
    end

    // entry count
    always_comb begin
        held_count_next = held_count_reg;
        if (cmd.cnt_clear) begin
            held_count_next = '0;
        end else if (cmd.insert && (held_count_reg < CNT_W'(LIST_DEPTH))) begin
            held_count_next = held_count_reg + CNT_W'(1);
        end
    end

    // listing index
    always_comb begin
        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc && !stat.idx_last) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= '0;
            idx_reg        <= '0;
        end else begin
            held_count_reg <= held_count_next;
            idx_reg        <= idx_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load_status) begin
            out_status_reg <= verdict;
            out_rank_reg   <= '0;
            out_id_reg     <= '0;
            out_score_reg  <= '0;
            out_count_reg  <= (verdict == STAT_CLEARED) ? '0 : COUNT_W'(held_count_reg);
            out_last_reg   <= 1'b1;
        end else if (cmd.out_load_entry) begin
            out_status_reg <= STAT_INSERTED;
            out_rank_reg   <= RANK_W'(idx_reg);
            out_id_reg     <= held_id_reg[idx_reg];
            out_score_reg  <= held_score_reg[idx_reg];
            out_count_reg  <= COUNT_W'(held_count_reg);
            out_last_reg   <= stat.idx_last;
        end
    end

    assign m_tdata = {{M_PAD_W{1'b0}}, out_count_reg, out_score_reg, out_id_reg, out_rank_reg};
    assign m_tuser = out_status_reg;
    assign m_tlast = out_last_reg;

    // checks
    `TKCL_ASSERT(a_count_in_range, held_count_reg <= CNT_W'(LIST_DEPTH))
    `TKCL_ASSERT_IMPLY(a_list_idx_held, cmd.out_load_entry, CNT_W'(idx_reg) < held_count_reg)
    `TKCL_ASSERT_IMPLY(a_insert_grows, cmd.insert,
        ##1 ((held_count_reg == $past(held_count_reg) + CNT_W'(1)) ||
             (held_count_reg == CNT_W'(LIST_DEPTH))))

endmodule

// File: rtl/tkcl_ctrl.sv
// controller state machine: request intake, decision and listing sequence
`include "top_k_candidate_list_unit_defines.svh"

module tkcl_ctrl
    import tkcl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic        out_free;

    // result register can take a new item
    assign out_free = !m_tvalid_reg || m_tready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.req_load = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.verdict == STAT_INSERTED) begin
                    cmd.insert  = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_LIST;
                end else if (out_free) begin
                    cmd.out_load_status = 1'b1;
                    cmd.cnt_clear       = (stat.verdict == STAT_CLEARED);
                    state_next          = S_IDLE;
                end
            end
            S_LIST: begin
                if (out_free) begin
                    cmd.out_load_entry = 1'b1;
                    cmd.idx_inc        = 1'b1;
                    if (stat.idx_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        if (cmd.out_load_status || cmd.out_load_entry) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // checks
    `TKCL_ASSERT_IMPLY(a_no_overwrite, cmd.out_load_status || cmd.out_load_entry,
        !m_tvalid_reg || m_tready)
    `TKCL_ASSERT_IMPLY(a_list_after_insert, cmd.insert, ##1 (state_reg == S_LIST))
    `TKCL_ASSERT_IMPLY(a_last_ends_list,
        (state_reg == S_LIST) && out_free && stat.idx_last,
        ##1 ((state_reg == S_IDLE) && m_tvalid_reg))

endmodule

// File: sim/tb_top_k_candidate_list_unit.sv
// self-checking stream testbench for the top-k candidate list unit
module tb_top_k_candidate_list_unit
    import tkcl_pkg::*;
();

    // one result as seen on the m_ stream
    typedef struct packed {
        status_t              status;
        logic [RANK_W-1:0]    rank;
        logic [ID_W-1:0]      entry_id;
        logic [SCORE_W-1:0]   entry_score;
        logic [COUNT_W-1:0]   entry_count;
        logic                 last;
    } list_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // cand_id, cand_score, from bit 0 up
    logic [S_TUSER_W-1:0] s_tuser;   // action, no_chance, from bit 0 up
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // rank, entry_id, entry_score, entry_count, pad
    logic [M_TUSER_W-1:0] m_tuser;   // status
    logic                 m_tlast;

    // mirror of the list held by the block
    logic [ID_W-1:0]      shadow_ids[LIST_DEPTH];
    logic [SCORE_W-1:0]   shadow_scores[LIST_DEPTH];
    int                   shadow_count;

    list_result_t         due_results[$];
    int                   fault_count;
    int                   report_count;
    int                   burst_left;
    int                   hold_off_cycles;

    top_k_candidate_list_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // overall time limit
    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    // single result for a clear or a turned-away offer
    function automatic void expect_single(input status_t code);
        due_results.push_back('{code, '0, '0, '0, COUNT_W'(shadow_count), 1'b1});
    endfunction

    // work out the results one request causes and update the mirror
    function automatic void rank_candidate(input logic act, input logic [ID_W-1:0] id,
                                           input logic [SCORE_W-1:0] score, input logic nc);
        int  slot;
        int  k;
        bit  placed;
        bit  held;
        slot   = 0;
        placed = 1'b0;
        held   = 1'b0;
        if (act == ACT_CLEAR) begin
            shadow_count = 0;
            expect_single(STAT_CLEARED);
        end else if (nc) begin
            expect_single(STAT_NO_CHANCE);
        end else begin
            // first held entry with a strictly higher score
            for (k = 0; k < shadow_count; k++) begin
                if (!placed && score < shadow_scores[k]) begin
                    slot   = k;
                    placed = 1'b1;
                end
                if (shadow_ids[k] == id)
                    held = 1'b1;
            end
            if (!placed)
                slot = shadow_count;
            if (held) begin
                expect_single(STAT_DUPLICATE);
            end else if (slot >= LIST_DEPTH) begin
                expect_single(STAT_FULL_WORSE);
            end else begin
                // worse entries move down, the worst falls out when full
                for (k = (shadow_count < LIST_DEPTH) ? shadow_count : LIST_DEPTH - 1;
                     k > slot; k--) begin
                    shadow_ids[k]    = shadow_ids[k - 1];
                    shadow_scores[k] = shadow_scores[k - 1];
                end
                shadow_ids[slot]    = id;
                shadow_scores[slot] = score;
                if (shadow_count < LIST_DEPTH)
                    shadow_count++;
                for (k = 0; k < shadow_count; k++)
                    due_results.push_back('{STAT_INSERTED, RANK_W'(k), shadow_ids[k],
                                            shadow_scores[k], COUNT_W'(shadow_count),
                                            (k == shadow_count - 1)});
            end
        end
    endfunction

    // offer one request in bursts with random gaps, called at a falling edge
    task automatic send_request(input logic act, input logic [ID_W-1:0] id,
                                input logic [SCORE_W-1:0] score, input logic nc);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(1, 4);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {score, id};
        s_tuser  <= {nc, act};
        do @(posedge aclk); while (!s_tready);
        rank_candidate(act, id, score, nc);
        @(negedge aclk);
    endtask

    // hold the sender until every listing has come back
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (due_results.size() != 0);
    endtask

    task automatic test_directed_cases();
        send_request(ACT_CLEAR, 16'd0, 16'd0, 1'b0);          // clear on empty list
        send_request(ACT_OFFER, 16'd5, 16'd5, 1'b1);          // no chance, empty
        send_request(ACT_OFFER, 16'h0000, 16'h0000, 1'b0);    // lowest id and score
        send_request(ACT_OFFER, 16'hFFFF, 16'hFFFF, 1'b0);    // highest id and score
        send_request(ACT_OFFER, 16'h0000, 16'd100, 1'b0);     // id already held
        send_request(ACT_OFFER, 16'd100, 16'd0, 1'b0);        // equal best score goes after
        send_request(ACT_OFFER, 16'd200, 16'hFFFF, 1'b0);     // equal worst score goes after
        send_request(ACT_OFFER, 16'd300, 16'd1000, 1'b0);
        send_request(ACT_OFFER, 16'd301, 16'd2000, 1'b0);
        send_request(ACT_OFFER, 16'd302, 16'd500, 1'b0);
        send_request(ACT_OFFER, 16'd303, 16'd1500, 1'b0);     // list now full
        send_request(ACT_OFFER, 16'd900, 16'hFFFF, 1'b0);     // full, ties the last entry
        send_request(ACT_OFFER, 16'd200, 16'hFFFF, 1'b0);     // duplicate beats full and worse
        send_request(ACT_OFFER, 16'd901, 16'd1, 1'b1);        // no chance while full
        send_request(ACT_OFFER, 16'd902, 16'd0, 1'b0);        // full, worst drops out
        send_request(ACT_OFFER, 16'd903, 16'd1500, 1'b0);     // tie in the middle
        send_request(ACT_OFFER, 16'd100, 16'd0, 1'b1);        // no chance checked before duplicate
        send_request(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1);    // clear ignores other fields
        send_request(ACT_OFFER, 16'hFFFF, 16'hFFFF, 1'b1);
        send_request(ACT_OFFER, 16'd42, 16'd42, 1'b0);        // single entry listing
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_backpressure();
        int n;
        send_request(ACT_CLEAR, 16'd0, 16'd0, 1'b0);
        hold_off_cycles = 250;
        for (n = 0; n < 24; n++)
            send_request(ACT_OFFER, 16'(1000 + n), 16'($urandom_range(0, 65535)), 1'b0);
    endtask

    // sender goes quiet until all results are home, then resumes
    task automatic test_drain_pause();
        int n;
        for (n = 0; n < 12; n++) begin
            send_request(ACT_OFFER, 16'($urandom_range(0, 31)), 16'($urandom_range(0, 15)),
                         1'b0);
            if (n == 5)
                wait_for_drain();
        end
    endtask

    // random mix, mostly offers that reach the insert and reject paths
    task automatic test_random_traffic(input int count);
        int              n;
        int              pick;
        logic            act;
        logic            nc;
        logic [ID_W-1:0] id;
        logic [SCORE_W-1:0] score;
        for (n = 0; n < count; n++) begin
            act = ($urandom_range(0, 99) < 5) ? ACT_CLEAR : ACT_OFFER;
            nc  = ($urandom_range(0, 99) < 8);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                id = 16'($urandom_range(0, 31));
            else if (pick < 70 && shadow_count > 0)
                id = shadow_ids[$urandom_range(0, shadow_count - 1)];
            else
                id = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                score = 16'($urandom);
            else if (pick < 75)
                score = 16'($urandom_range(0, 15));
            else if (pick < 90 && shadow_count > 0)
                score = shadow_scores[$urandom_range(0, shadow_count - 1)];
            else
                score = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            send_request(act, id, score, nc);
            if ((n % 97) == 96)
                wait_for_drain();
        end
    endtask

    // receiver: own ready and stall runs, plus a counted long hold-off
    initial begin : result_sink
        int run_left;
        bit run_ready;
        run_left  = 0;
        run_ready = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                hold_off_cycles--;
            end else begin
                if (run_left == 0) begin
                    run_ready = !run_ready;
                    if (!run_ready && $urandom_range(0, 2) == 0)
                        run_ready = 1'b1;
                    if (run_ready)
                        run_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
                    else
                        run_left = $urandom_range(1, 7);
                end
                m_tready <= run_ready;
                run_left--;
            end
        end
    end

    // compare each taken result with the oldest one due
    initial begin : result_check
        list_result_t seen;
        list_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                seen = '{status_t'(m_tuser),
                         m_tdata[RANK_W-1:0],
                         m_tdata[RANK_W +: ID_W],
                         m_tdata[RANK_W + ID_W +: SCORE_W],
                         m_tdata[RANK_W + ID_W + SCORE_W +: COUNT_W],
                         m_tlast};
                if (due_results.size() == 0) begin
                    fault_count++;
                    if (report_count < 10) begin
                        report_count++;
                        $write("unexpected result: status %0d rank %0d id %0h",
                               seen.status, seen.rank, seen.entry_id);
                        $display(" score %0h count %0d last %0b",
                                 seen.entry_score, seen.entry_count, seen.last);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (seen !== want) begin
                        fault_count++;
                        if (report_count < 10) begin
                            report_count++;
                            $write("mismatch: expected status %0d rank %0d id %0h",
                                   want.status, want.rank, want.entry_id);
                            $display(" score %0h count %0d last %0b",
                                     want.entry_score, want.entry_count, want.last);
                            $write("          actual   status %0d rank %0d id %0h",
                                   seen.status, seen.rank, seen.entry_id);
                            $display(" score %0h count %0d last %0b",
                                     seen.entry_score, seen.entry_count, seen.last);
                        end
                    end
                end
            end
        end
    end

    // reset, tests in turn, drain and verdict
    initial begin : test_sequence
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        shadow_count    = 0;
        fault_count     = 0;
        report_count    = 0;
        burst_left      = 0;
        hold_off_cycles = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_cases();
        test_output_backpressure();
        test_drain_pause();
        test_random_traffic(403);
        wait_for_drain();
        // watch for stray results after the last one due
        repeat (24) @(negedge aclk);
        if (due_results.size() != 0) begin
            fault_count++;
            $display("results still outstanding: %0d", due_results.size());
        end
        if (fault_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
